// File: rtl/core/cbm_pkg.sv
// Shared types and constants for the cartridge bank mapper with IRQ.
package cbm_pkg;

  // Bus event kinds carried on s_axis_tuser
  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_LINE   = 2'd1,
    KIND_CYCLES = 2'd2
  } kind_e;

  // Configuration register indexes
  localparam logic REG_VARIANT     = 1'b0;
  localparam logic REG_HARD_MIRROR = 1'b1;

  localparam logic VARIANT_SCANLINE = 1'b0;
  localparam logic VARIANT_CYCLE    = 1'b1;

  localparam logic [3:0]  LINE_LIMIT     = 4'd8;
  localparam logic [7:0]  PRESCALE_DIV   = 8'd4;
  localparam logic [7:0]  PRESCALE_START = 8'd3;
  localparam logic [15:0] CYCLE_STEP     = 16'd5;
  localparam logic [3:0]  PRG_FIXED_C000 = 4'hE;
  localparam logic [3:0]  PRG_FIXED_E000 = 4'hF;

  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 112;

  // Result item; first field sits in the highest bits, last field in the lowest
  typedef struct packed {
    logic        irq_level;
    logic        mirroring;
    logic [15:0] chr_bank_3;
    logic [15:0] chr_bank_2;
    logic [15:0] chr_bank_1;
    logic [15:0] chr_bank_0;
    logic [10:0] prg_bank_e000;
    logic [10:0] prg_bank_c000;
    logic [10:0] prg_bank_a000;
    logic [10:0] prg_bank_8000;
  } result_t;

endpackage

// File: rtl/core/cartridge_bank_mapper_with_irq.sv
// Cartridge bank mapper with scanline or cycle IRQ, one result per bus event.
//
// Usage:
//   s_axis: one bus event per transaction. tuser carries the kind (CPU write,
//   scanline tick, CPU cycle report); tdata carries address, write data and
//   cycle count. m_axis: one result per event with the full bank map, the
//   mirroring bit and the IRQ level, taken after the event is applied.
//   cfg: index/data write channel for variant and hard_mirroring, always
//   ready; write only while no result is outstanding.
// Timing: the result is registered and is valid in the cycle after its event is accepted.
// Throughput: one event per cycle while no result waits or m_axis_tready is high;
//   the mapper state and the output register update in the same cycle the event is accepted.
// Stall: while m_axis_tready is low a waiting result holds and s_axis_tready
//   drops; when the result is taken a new event is accepted in that cycle.
// Reset: banks return to CHR 0,1,2,3 and PRG 0,1, outer bank, IRQ state and
//   counters clear, both configuration registers clear, no result pending.
module cartridge_bank_mapper_with_irq (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic                             cfg_index_i,
  input  logic                             cfg_data_i,
  // bus events
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata fields from bit 0: address[15:0], wdata[7:0], cycles[2:0], zero pad
  input  logic [cbm_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // tuser fields from bit 0: kind[1:0]
  input  logic [1:0]                       s_axis_tuser,
  // results
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata fields from bit 0: prg_bank_8000[10:0], prg_bank_a000[10:0],
  // prg_bank_c000[10:0], prg_bank_e000[10:0], chr_bank_0[15:0],
  // chr_bank_1[15:0], chr_bank_2[15:0], chr_bank_3[15:0], mirroring,
  // irq_level, zero pad
  output logic [cbm_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

  logic        variant_q, hard_mirror_q;
  logic [7:0]  chr_sel_q [4];
  logic [7:0]  chr_sel_d [4];
  logic [3:0]  prg_sel_q [2];
  logic [3:0]  prg_sel_d [2];
  logic [7:0]  outer_q, outer_d;
  logic        mirror_q, mirror_d;
  logic        irq_en_q, irq_en_d;
  logic [3:0]  line_q, line_d;
  logic [7:0]  presc_q, presc_d;
  logic [15:0] cyc_cnt_q, cyc_cnt_d;
  logic        irq_pend_q, irq_pend_d;

  logic                 out_valid_q;
  cbm_pkg::result_t     result_q, result_d;

  logic        in_fire;
  logic [15:0] addr;
  logic [7:0]  wdata;
  logic [2:0]  cycles;
  logic [7:0]  presc_sum;
  logic [15:0] cyc_dec;
  logic [3:0]  line_inc;
  logic [10:0] prg_base;
  logic [15:0] chr_base;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign addr   = s_axis_tdata[15:0];
  assign wdata  = s_axis_tdata[23:16];
  assign cycles = s_axis_tdata[26:24];

  assign presc_sum = presc_q + {5'd0, cycles};
  assign cyc_dec   = cyc_cnt_q - cbm_pkg::CYCLE_STEP;
  assign line_inc  = line_q + 4'd1;

  always_comb begin
    chr_sel_d  = chr_sel_q;
    prg_sel_d  = prg_sel_q;
    outer_d    = outer_q;
    mirror_d   = mirror_q;
    irq_en_d   = irq_en_q;
    line_d     = line_q;
    presc_d    = presc_q;
    cyc_cnt_d  = cyc_cnt_q;
    irq_pend_d = irq_pend_q;
    case (cbm_pkg::kind_e'(s_axis_tuser))
      cbm_pkg::KIND_WRITE: begin
        if (addr[15:12] == 4'h6) begin
          if (variant_q == cbm_pkg::VARIANT_CYCLE) begin
            unique case (addr[2:0]) inside
              3'd0, 3'd1, 3'd2, 3'd3: chr_sel_d[addr[1:0]] = wdata;
              3'd4, 3'd5:             mirror_d = wdata[0];
              3'd6:                   cyc_cnt_d = {cyc_cnt_q[15:8], wdata};
              default:                cyc_cnt_d = {wdata, cyc_cnt_q[7:0]};
            endcase
          end else begin
            chr_sel_d[addr[1:0]] = wdata;
          end
        end else if (addr[15:12] == 4'h7) begin
          unique case (addr[1:0]) inside
            2'd0, 2'd1: prg_sel_d[addr[0]] = wdata[3:0];
            2'd2: begin
              irq_en_d   = 1'b0;
              line_d     = '0;
              irq_pend_d = 1'b0;
            end
            default: begin
              irq_en_d   = 1'b1;
              presc_d    = cbm_pkg::PRESCALE_START;
              irq_pend_d = 1'b0;
            end
          endcase
        end else if (addr[15:13] == 3'b100) begin
          outer_d = addr[7:0];
        end
      end
      cbm_pkg::KIND_LINE: begin
        if (variant_q != cbm_pkg::VARIANT_CYCLE && irq_en_q &&
            line_q < cbm_pkg::LINE_LIMIT) begin
          line_d = line_inc;
          if (line_inc >= cbm_pkg::LINE_LIMIT) irq_pend_d = 1'b1;
        end
      end
      cbm_pkg::KIND_CYCLES: begin
        if (variant_q == cbm_pkg::VARIANT_CYCLE) begin
          presc_d = presc_sum;
          if (presc_sum >= cbm_pkg::PRESCALE_DIV) begin
            presc_d   = presc_sum - cbm_pkg::PRESCALE_DIV;
            cyc_cnt_d = cyc_dec;
            // fire at or below zero as a signed count
            if ((cyc_dec == '0 || cyc_dec[15]) && irq_en_q) irq_pend_d = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // Result reflects the state after this transaction
  assign prg_base = {outer_d[7:1], 4'd0};
  assign chr_base = {outer_d, 8'd0};

  always_comb begin
    result_d.prg_bank_8000 = prg_base | {7'd0, prg_sel_d[0]};
    result_d.prg_bank_a000 = prg_base | {7'd0, prg_sel_d[1]};
    result_d.prg_bank_c000 = prg_base | {7'd0, cbm_pkg::PRG_FIXED_C000};
    result_d.prg_bank_e000 = prg_base | {7'd0, cbm_pkg::PRG_FIXED_E000};
    result_d.chr_bank_0    = chr_base | {8'd0, chr_sel_d[0]};
    result_d.chr_bank_1    = chr_base | {8'd0, chr_sel_d[1]};
    result_d.chr_bank_2    = chr_base | {8'd0, chr_sel_d[2]};
    result_d.chr_bank_3    = chr_base | {8'd0, chr_sel_d[3]};
    result_d.mirroring     = (variant_q == cbm_pkg::VARIANT_CYCLE) ? !mirror_d
                                                                   : hard_mirror_q;
    result_d.irq_level     = irq_pend_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      variant_q     <= 1'b0;
      hard_mirror_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        cbm_pkg::REG_VARIANT:     variant_q     <= cfg_data_i;
        cbm_pkg::REG_HARD_MIRROR: hard_mirror_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chr_sel_q[0] <= 8'd0;
      chr_sel_q[1] <= 8'd1;
      chr_sel_q[2] <= 8'd2;
      chr_sel_q[3] <= 8'd3;
      prg_sel_q[0] <= 4'd0;
      prg_sel_q[1] <= 4'd1;
      outer_q      <= '0;
      mirror_q     <= 1'b0;
      irq_en_q     <= 1'b0;
      line_q       <= '0;
      presc_q      <= '0;
      cyc_cnt_q    <= '0;
      irq_pend_q   <= 1'b0;
    end else if (in_fire) begin
      chr_sel_q    <= chr_sel_d;
      prg_sel_q    <= prg_sel_d;
      outer_q      <= outer_d;
      mirror_q     <= mirror_d;
      irq_en_q     <= irq_en_d;
      line_q       <= line_d;
      presc_q      <= presc_d;
      cyc_cnt_q    <= cyc_cnt_d;
      irq_pend_q   <= irq_pend_d;
    end
  end

  // Output register: load on accept, drop valid once the result is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(cbm_pkg::OUT_DATA_W - $bits(cbm_pkg::result_t)){1'b0}}, result_q};

endmodule
